// ===== rtl/core/kcdt_pkg.sv =====
// Package: shared types and constants of the keyed counter delta table.
`default_nettype none
package kcdt_pkg;

    localparam int ID_W      = 22;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 16;

    typedef enum logic [1:0] {
        FUNC_BEGIN  = 2'd0,
        FUNC_SAMPLE = 2'd1,
        FUNC_END    = 2'd2,
        FUNC_NONE   = 2'd3
    } func_t;

    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT     = 1'd1;

    typedef struct packed {
        logic [1:0]      func;
        logic [ID_W-1:0] task_id;
        logic [63:0]     name_low;
        logic [63:0]     name_high;
        logic [63:0]     read_total;
        logic [63:0]     write_total;
        logic            detail_request;
    } in_item_t;

    typedef struct packed {
        logic [ID_W-1:0] out_id;
        logic [31:0]     read_kb;
        logic [31:0]     wr_kb;
        logic            report_flag;
        logic            detail_flag;
        logic            new_entry;
        logic            table_full;
        logic [10:0]     removed_count;
        logic [6:0]      reported_count;
        logic [6:0]      detailed_count;
    } out_item_t;

    // Back-end sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_LOOK,
        ST_CALC,
        ST_SWEEP,
        ST_CLEAR,
        ST_OUT
    } back_state_t;

endpackage
`default_nettype wire

// ===== rtl/core/kcdt_front.sv =====
// Front end: accepts items, cleans the name, and holds them in a two-entry queue.
`default_nettype none
module kcdt_front #(
    parameter int NAME_BYTES = 16
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  kcdt_pkg::in_item_t   in_item,
    input  wire                  in_valid,
    output logic                 in_stall,
    output kcdt_pkg::in_item_t   q_item,
    output logic                 q_valid,
    input  wire                  q_pop
);
    kcdt_pkg::in_item_t mem_reg [2];
    logic               wr_ptr_reg, rd_ptr_reg;
    logic [1:0]         cnt_reg;
    logic [127:0]       name_clean;
    kcdt_pkg::in_item_t cleaned;
    logic               push;

    // Zero every byte after the first zero byte or past NAME_BYTES
    always_comb
    begin
        logic ended;
        ended = 1'b0;
        name_clean = {in_item.name_high, in_item.name_low};
        for (int i = 0; i < 16; i++)
        begin
            if (i >= NAME_BYTES || name_clean[i*8 +: 8] == 8'd0)
                ended = 1'b1;
            if (ended)
                name_clean[i*8 +: 8] = 8'd0;
        end
        cleaned = in_item;
        cleaned.name_low  = name_clean[63:0];
        cleaned.name_high = name_clean[127:64];
    end

    assign in_stall = (cnt_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = mem_reg[rd_ptr_reg];

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= cleaned;
    end

    // Queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (q_pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, q_pop};
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/kcdt_back.sv =====
// Back end: table lookup, update, sweeps and result register.
`default_nettype none
module kcdt_back #(
    parameter int BUCKETS = 256,
    parameter int WAYS    = 4
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  kcdt_pkg::in_item_t   q_item,
    input  wire                  q_valid,
    output logic                 q_pop,
    input  wire  [15:0]          threshold,
    input  wire  [6:0]           limit,
    output kcdt_pkg::out_item_t  out_item,
    output logic                 out_valid,
    input  wire                  out_stall
);
    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int ENTRIES = BUCKETS * WAYS;
    localparam int EW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int ROW_W = kcdt_pkg::ID_W + 4 * 64;

    // Entry rows: id, name, totals; one memory row per entry
    logic [ROW_W-1:0] row_mem [ENTRIES];
    logic [ROW_W-1:0] row_rd_reg;
    // Valid and seen marks, one word per bucket
    logic [WAYS-1:0] valid_mem [BUCKETS];
    logic [WAYS-1:0] seen_mem  [BUCKETS];
    logic [WAYS-1:0] vrd_reg, srd_reg;
    // Buckets written since reset; the others read as empty
    logic [BUCKETS-1:0] known_reg;

    kcdt_pkg::back_state_t state_reg, state_next;
    kcdt_pkg::in_item_t item_reg;
    logic [WW-1:0]  way_reg;
    logic           hit_reg, free_reg;
    logic [WW-1:0]  free_way_reg;
    logic [WW:0]    scan_way_reg;
    logic [BW:0]    sweep_reg;
    logic [10:0]    removed_reg;
    logic [11:0]    removed_sum;
    logic [6:0]     rep_reg, det_reg;
    logic           is_detail_reg;
    kcdt_pkg::out_item_t work_reg;
    kcdt_pkg::out_item_t res_reg, res_next;
    logic           out_valid_reg, out_valid_next;
    logic           res_load;
    logic [63:0]    dr, dw, sum;
    logic [BW-1:0]  bucket;
    logic [BW-1:0]  q_bucket;
    logic [EW-1:0]  row_addr;
    logic [ROW_W-1:0] row_match;

    // Bucket is the low bits of the id (BUCKETS is a power of two)
    assign bucket   = BW'(item_reg.task_id % BUCKETS);
    assign q_bucket = BW'(q_item.task_id % BUCKETS);
    assign row_addr = EW'({bucket, way_reg});
    assign row_match = {item_reg.task_id, item_reg.name_low, item_reg.name_high,
                        item_reg.read_total, item_reg.write_total};
    assign removed_sum = 12'(removed_reg) + 12'($countones(vrd_reg & ~srd_reg));

    // Deltas from the row read in the previous step
    always_comb
    begin
        if (hit_reg)
        begin
            dr = item_reg.read_total  - row_rd_reg[127:64];
            dw = item_reg.write_total - row_rd_reg[63:0];
        end
        else
        begin
            dr = item_reg.read_total;
            dw = item_reg.write_total;
        end
        sum = dr + dw;
    end

    // Result register loads when empty or when its item leaves
    assign res_load       = (state_reg == kcdt_pkg::ST_OUT) && (!out_valid_reg || !out_stall);
    assign out_valid_next = res_load || (out_valid_reg && out_stall);

    always_comb
    begin
        res_next = work_reg;
        res_next.removed_count  = (item_reg.func == kcdt_pkg::FUNC_END) ? removed_reg : 11'd0;
        res_next.reported_count = rep_reg;
        res_next.detailed_count = det_reg;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = res_reg;
    assign q_pop     = (state_reg == kcdt_pkg::ST_IDLE) && q_valid;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            kcdt_pkg::ST_IDLE:
                if (q_valid)
                begin
                    case (kcdt_pkg::func_t'(q_item.func))
                        kcdt_pkg::FUNC_SAMPLE: state_next = kcdt_pkg::ST_READ;
                        kcdt_pkg::FUNC_BEGIN:  state_next = kcdt_pkg::ST_CLEAR;
                        kcdt_pkg::FUNC_END:    state_next = kcdt_pkg::ST_SWEEP;
                        default:               state_next = kcdt_pkg::ST_OUT;
                    endcase
                end
            kcdt_pkg::ST_READ:  state_next = kcdt_pkg::ST_LOOK;
            kcdt_pkg::ST_LOOK:
                if (hit_reg || scan_way_reg == (WW+1)'(WAYS))
                    state_next = kcdt_pkg::ST_CALC;
            kcdt_pkg::ST_CALC:  state_next = kcdt_pkg::ST_OUT;
            kcdt_pkg::ST_SWEEP,
            kcdt_pkg::ST_CLEAR:
                if (sweep_reg == (BW+1)'(BUCKETS))
                    state_next = kcdt_pkg::ST_OUT;
            kcdt_pkg::ST_OUT:
                if (res_load)
                    state_next = kcdt_pkg::ST_IDLE;
            default: state_next = kcdt_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= kcdt_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Sequencing datapath: search flags, sweep walk, scan counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rep_reg       <= 7'd0;
            det_reg       <= 7'd0;
            is_detail_reg <= 1'b0;
            sweep_reg     <= '0;
            scan_way_reg  <= '0;
            hit_reg       <= 1'b0;
            free_reg      <= 1'b0;
            removed_reg   <= 11'd0;
        end
        else
        begin
            case (state_reg)
                kcdt_pkg::ST_IDLE:
                    if (q_valid)
                    begin
                        sweep_reg    <= '0;
                        scan_way_reg <= '0;
                        hit_reg      <= 1'b0;
                        free_reg     <= 1'b0;
                        removed_reg  <= 11'd0;
                        if (q_item.func == kcdt_pkg::FUNC_BEGIN)
                        begin
                            rep_reg       <= 7'd0;
                            det_reg       <= 7'd0;
                            is_detail_reg <= q_item.detail_request;
                        end
                    end
                kcdt_pkg::ST_LOOK:
                    if (!hit_reg && scan_way_reg != (WW+1)'(WAYS))
                    begin
                        scan_way_reg <= scan_way_reg + 1'b1;
                        if (vrd_reg[way_reg] && row_rd_reg[ROW_W-1:128] ==
                            row_match[ROW_W-1:128])
                            hit_reg <= 1'b1;
                        else if (!vrd_reg[way_reg] && !free_reg)
                            free_reg <= 1'b1;
                    end
                kcdt_pkg::ST_CALC:
                begin
                    if ((sum[63:20] > 44'(threshold)) && rep_reg < limit)
                        rep_reg <= rep_reg + 7'd1;
                    if (is_detail_reg && sum != 64'd0 && det_reg < limit)
                        det_reg <= det_reg + 7'd1;
                end
                kcdt_pkg::ST_SWEEP:
                begin
                    if (sweep_reg != (BW+1)'(BUCKETS))
                        sweep_reg <= sweep_reg + 1'b1;
                    // Marks of the previous bucket are in vrd_reg and srd_reg
                    if (sweep_reg != '0)
                        removed_reg <= (removed_sum > 12'd2047) ? 11'd2047 :
                                       removed_sum[10:0];
                end
                kcdt_pkg::ST_CLEAR:
                    if (sweep_reg != (BW+1)'(BUCKETS))
                        sweep_reg <= sweep_reg + 1'b1;
                default: ;
            endcase
        end
    end

    // Payload of the working item and the result
    always_ff @(posedge clk)
    begin
        case (state_reg)
            kcdt_pkg::ST_IDLE:
                if (q_valid)
                begin
                    item_reg <= q_item;
                    way_reg  <= '0;
                    work_reg <= '0;
                end
            kcdt_pkg::ST_LOOK:
                if (!hit_reg && scan_way_reg != (WW+1)'(WAYS))
                begin
                    if (!(vrd_reg[way_reg] && row_rd_reg[ROW_W-1:128] ==
                          row_match[ROW_W-1:128]))
                    begin
                        if (!vrd_reg[way_reg] && !free_reg)
                            free_way_reg <= way_reg;
                        way_reg <= WW'(scan_way_reg + 1'b1);
                    end
                end
            kcdt_pkg::ST_CALC:
            begin
                work_reg.out_id      <= item_reg.task_id;
                work_reg.read_kb     <= dr[41:10];
                work_reg.wr_kb       <= dw[41:10];
                work_reg.report_flag <= (sum[63:20] > 44'(threshold)) && rep_reg < limit;
                work_reg.detail_flag <= is_detail_reg && sum != 64'd0 && det_reg < limit;
                work_reg.new_entry   <= !hit_reg;
                work_reg.table_full  <= !hit_reg && !free_reg;
            end
            kcdt_pkg::ST_OUT:
                if (res_load)
                    res_reg <= res_next;
            default: ;
        endcase
    end

    // Row memory: read in lookup, write on update or insert
    always_ff @(posedge clk)
    begin
        if (state_reg == kcdt_pkg::ST_READ || state_reg == kcdt_pkg::ST_LOOK)
            row_rd_reg <= row_mem[EW'({bucket, (state_reg == kcdt_pkg::ST_LOOK &&
                !(vrd_reg[way_reg] && row_rd_reg[ROW_W-1:128] ==
                row_match[ROW_W-1:128]) && scan_way_reg != (WW+1)'(WAYS)) ?
                WW'(scan_way_reg + 1'b1) : way_reg})];
        if (state_reg == kcdt_pkg::ST_CALC && (hit_reg || free_reg))
            row_mem[hit_reg ? row_addr : EW'({bucket, free_way_reg})] <= row_match;
    end

    // Mark memories: one read port, one write port each
    always_ff @(posedge clk)
    begin
        case (state_reg)
            kcdt_pkg::ST_IDLE:
                if (q_valid)
                begin
                    vrd_reg <= known_reg[q_bucket] ? valid_mem[q_bucket] : '0;
                    srd_reg <= seen_mem[q_bucket];
                end
            kcdt_pkg::ST_CALC:
                if (hit_reg || free_reg)
                begin
                    valid_mem[bucket] <= vrd_reg | (WAYS'(1) <<
                        (hit_reg ? way_reg : free_way_reg));
                    seen_mem[bucket]  <= srd_reg | (WAYS'(1) <<
                        (hit_reg ? way_reg : free_way_reg));
                end
            kcdt_pkg::ST_SWEEP:
            begin
                if (sweep_reg != (BW+1)'(BUCKETS))
                begin
                    vrd_reg <= known_reg[BW'(sweep_reg)] ? valid_mem[BW'(sweep_reg)] : '0;
                    srd_reg <= seen_mem[BW'(sweep_reg)];
                end
                if (sweep_reg != '0)
                    valid_mem[BW'(sweep_reg - 1'b1)] <= vrd_reg & srd_reg;
            end
            kcdt_pkg::ST_CLEAR:
                if (sweep_reg != (BW+1)'(BUCKETS))
                    seen_mem[BW'(sweep_reg)] <= '0;
            default: ;
        endcase
    end

    // A bucket becomes known at its first mark write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            known_reg <= '0;
        else if (state_reg == kcdt_pkg::ST_CALC && (hit_reg || free_reg))
            known_reg[bucket] <= 1'b1;
    end
endmodule
`default_nettype wire

// ===== rtl/core/keyed_counter_delta_table_unit.sv =====
// Top level: keyed counter delta table with decoupled front end and back end.
`default_nettype none
// Items pass a two-item queue before the back end takes them. A sample then
// passes one mark read, one row read, one compare step per way searched plus
// one, one update step and one result step in the back end. A begin-scan or
// end-scan item walks every bucket once. The back end takes the next item only
// after its result is in the result register, which holds it while the receiver
// stalls; the result step waits for as long as that register still holds a
// result that the receiver stalls.
module keyed_counter_delta_table_unit #(
    parameter int BUCKETS    = 256,
    parameter int WAYS       = 4,
    parameter int NAME_BYTES = 16
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  kcdt_pkg::in_item_t   in_item,
    input  wire                  in_valid,
    output logic                 in_stall,
    output kcdt_pkg::out_item_t  out_item,
    output logic                 out_valid,
    input  wire                  out_stall,
    input  wire                  cfg_valid,
    output logic                 cfg_ready,
    input  wire  [kcdt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire  [kcdt_pkg::CFG_DAT_W-1:0] cfg_data
);
    kcdt_pkg::in_item_t q_item;
    logic               q_valid, q_pop;
    logic [15:0]        threshold_reg;
    logic [6:0]         limit_reg;

    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= 16'd2;
            limit_reg     <= 7'd100;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                kcdt_pkg::REG_THRESHOLD: threshold_reg <= cfg_data;
                kcdt_pkg::REG_LIMIT:     limit_reg     <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    kcdt_front #(.NAME_BYTES(NAME_BYTES)) u_front (
        .clk(clk), .rst_n(rst_n), .in_item(in_item), .in_valid(in_valid),
        .in_stall(in_stall), .q_item(q_item), .q_valid(q_valid), .q_pop(q_pop)
    );

    kcdt_back #(.BUCKETS(BUCKETS), .WAYS(WAYS)) u_back (
        .clk(clk), .rst_n(rst_n), .q_item(q_item), .q_valid(q_valid),
        .q_pop(q_pop), .threshold(threshold_reg), .limit(limit_reg),
        .out_item(out_item), .out_valid(out_valid), .out_stall(out_stall)
    );
endmodule
`default_nettype wire

// ===== rtl/core/kcdt_checker.sv =====
// Checker on the top-level ports, bound to the top level.
`default_nettype none
module kcdt_checker (
    input wire                 clk,
    input wire                 rst_n,
    input kcdt_pkg::out_item_t out_item,
    input wire                 out_valid,
    input wire                 out_stall
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_item))
        else $error("result changed while stalled");
    a_full_new: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.table_full |-> out_item.new_entry)
        else $error("full without new entry");
    a_rep_lim: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.report_flag |-> out_item.reported_count != 7'd0)
        else $error("report flag with zero count");
    a_det_lim: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.detail_flag |-> out_item.detailed_count != 7'd0)
        else $error("detail flag with zero count");
endmodule

bind keyed_counter_delta_table_unit kcdt_checker u_kcdt_checker (
    .clk(clk), .rst_n(rst_n), .out_item(out_item), .out_valid(out_valid),
    .out_stall(out_stall)
);
`default_nettype wire

// ===== verif/keyed_counter_delta_table_unit_tb.sv =====
// Testbench: keyed counter delta table unit, scan sequences against a scoreboard predictor.
`default_nettype none
module keyed_counter_delta_table_unit_tb;

    localparam int N_BUCKETS   = 256;
    localparam int N_WAYS      = 4;
    localparam int N_ENTRIES   = N_BUCKETS * N_WAYS;
    localparam int POOL_SIZE   = 64;
    localparam int CYCLE_LIMIT = 1500000;
    localparam int SWEEP_WAIT  = N_BUCKETS + 40;

    // Predictor of the table and scan counters plus the queue of expected items
    class delta_table_scoreboard;
        bit          valid_tbl [N_ENTRIES];
        bit          seen_tbl  [N_ENTRIES];
        bit [21:0]   id_tbl    [N_ENTRIES];
        bit [127:0]  name_tbl  [N_ENTRIES];
        bit [63:0]   rd_tbl    [N_ENTRIES];
        bit [63:0]   wr_tbl    [N_ENTRIES];
        bit [15:0]   thresh_mb;
        bit [6:0]    limit;
        bit [6:0]    reported;
        bit [6:0]    detailed;
        bit          detail_scan;
        kcdt_pkg::out_item_t expected_q [$];
        int          errors;
        int          noted;

        function void reset_state();
            for (int i = 0; i < N_ENTRIES; i++)
            begin
                valid_tbl[i] = 0;
                seen_tbl[i]  = 0;
            end
            thresh_mb   = 16'd2;
            limit       = 7'd100;
            reported    = '0;
            detailed    = '0;
            detail_scan = 0;
            errors      = 0;
            noted       = 0;
        endfunction

        function void set_reg(logic [kcdt_pkg::CFG_IDX_W-1:0] idx,
                              logic [kcdt_pkg::CFG_DAT_W-1:0] data);
            if (idx == kcdt_pkg::REG_THRESHOLD)
                thresh_mb = data;
            else
                limit = data[6:0];
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Bytes after the first zero byte do not belong to the name
        function bit [127:0] clean_name(bit [127:0] n);
            bit ended;
            ended = 0;
            for (int i = 0; i < 16; i++)
            begin
                if (n[i*8 +: 8] == 8'd0)
                    ended = 1;
                if (ended)
                    n[i*8 +: 8] = 8'd0;
            end
            return n;
        endfunction

        function void note_input(kcdt_pkg::in_item_t it);
            kcdt_pkg::out_item_t e;
            bit [127:0] nm;
            int         base;
            int         hit;
            int         free_way;
            bit [63:0]  dr;
            bit [63:0]  dw;
            bit [63:0]  sum;
            int         removed;
            e = '0;
            noted++;
            case (kcdt_pkg::func_t'(it.func))
                kcdt_pkg::FUNC_BEGIN:
                begin
                    for (int i = 0; i < N_ENTRIES; i++)
                        seen_tbl[i] = 0;
                    reported    = '0;
                    detailed    = '0;
                    detail_scan = it.detail_request;
                end
                kcdt_pkg::FUNC_SAMPLE:
                begin
                    base     = (int'(it.task_id) % N_BUCKETS) * N_WAYS;
                    hit      = -1;
                    free_way = -1;
                    nm       = clean_name({it.name_high, it.name_low});
                    for (int k = 0; k < N_WAYS; k++)
                    begin
                        if (valid_tbl[base+k])
                        begin
                            if (hit < 0 && id_tbl[base+k] == it.task_id &&
                                name_tbl[base+k] == nm)
                                hit = base + k;
                        end
                        else if (free_way < 0)
                            free_way = base + k;
                    end
                    if (hit >= 0)
                    begin
                        dr = it.read_total - rd_tbl[hit];
                        dw = it.write_total - wr_tbl[hit];
                        rd_tbl[hit]   = it.read_total;
                        wr_tbl[hit]   = it.write_total;
                        seen_tbl[hit] = 1;
                    end
                    else
                    begin
                        e.new_entry = 1;
                        dr = it.read_total;
                        dw = it.write_total;
                        if (free_way >= 0)
                        begin
                            valid_tbl[free_way] = 1;
                            seen_tbl[free_way]  = 1;
                            id_tbl[free_way]    = it.task_id;
                            name_tbl[free_way]  = nm;
                            rd_tbl[free_way]    = it.read_total;
                            wr_tbl[free_way]    = it.write_total;
                        end
                        else
                            e.table_full = 1;
                    end
                    sum       = dr + dw;
                    e.out_id  = it.task_id;
                    e.read_kb = dr[41:10];
                    e.wr_kb   = dw[41:10];
                    if (sum[63:20] > thresh_mb && reported < limit)
                    begin
                        reported++;
                        e.report_flag = 1;
                    end
                    if (detail_scan && sum != 0 && detailed < limit)
                    begin
                        detailed++;
                        e.detail_flag = 1;
                    end
                end
                kcdt_pkg::FUNC_END:
                begin
                    removed = 0;
                    for (int i = 0; i < N_ENTRIES; i++)
                    begin
                        if (valid_tbl[i] && !seen_tbl[i])
                        begin
                            valid_tbl[i] = 0;
                            if (removed < 2047)
                                removed++;
                        end
                    end
                    e.removed_count = 11'(removed);
                end
                default: ;
            endcase
            e.reported_count = reported;
            e.detailed_count = detailed;
            expected_q.push_back(e);
        endfunction

        task report(string msg);
            $display("MISMATCH: %s", msg);
            errors++;
        endtask

        task check_result(kcdt_pkg::out_item_t got);
            kcdt_pkg::out_item_t e;
            if (expected_q.size() == 0)
            begin
                report("result item with nothing expected");
                return;
            end
            e = expected_q.pop_front();
            if (got.out_id !== e.out_id)
                report($sformatf("out_id got %h exp %h", got.out_id, e.out_id));
            if (got.read_kb !== e.read_kb)
                report($sformatf("read_kb got %h exp %h", got.read_kb, e.read_kb));
            if (got.wr_kb !== e.wr_kb)
                report($sformatf("wr_kb got %h exp %h", got.wr_kb, e.wr_kb));
            if (got.report_flag !== e.report_flag)
                report($sformatf("report_flag got %b exp %b", got.report_flag, e.report_flag));
            if (got.detail_flag !== e.detail_flag)
                report($sformatf("detail_flag got %b exp %b", got.detail_flag, e.detail_flag));
            if (got.new_entry !== e.new_entry)
                report($sformatf("new_entry got %b exp %b", got.new_entry, e.new_entry));
            if (got.table_full !== e.table_full)
                report($sformatf("table_full got %b exp %b", got.table_full, e.table_full));
            if (got.removed_count !== e.removed_count)
                report($sformatf("removed_count got %0d exp %0d",
                                 got.removed_count, e.removed_count));
            if (got.reported_count !== e.reported_count)
                report($sformatf("reported_count got %0d exp %0d",
                                 got.reported_count, e.reported_count));
            if (got.detailed_count !== e.detailed_count)
                report($sformatf("detailed_count got %0d exp %0d",
                                 got.detailed_count, e.detailed_count));
        endtask
    endclass

    logic                  clk;
    logic                  rst_n;
    kcdt_pkg::in_item_t    in_item;
    logic                  in_valid;
    logic                  in_stall;
    kcdt_pkg::out_item_t   out_item;
    logic                  out_valid;
    logic                  out_stall;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [kcdt_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [kcdt_pkg::CFG_DAT_W-1:0] cfg_data;

    delta_table_scoreboard sb;
    int                    cycles = 0;
    int                    hold_cycles;
    int                    burst_left;
    int                    stall_mode;

    // Task key pool: the first 40 keys share buckets 0..7 so buckets overflow
    bit [21:0]   pool_id   [POOL_SIZE];
    bit [127:0]  pool_name [POOL_SIZE];
    bit [63:0]   pool_rd   [POOL_SIZE];
    bit [63:0]   pool_wr   [POOL_SIZE];

    keyed_counter_delta_table_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_item),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_item  (out_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 0;
    end

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("keyed_counter_delta_table_unit_tb: done, errors");
            $finish;
        end
    end

    // Result monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(out_item);
    end

    // Receiver stall: a forced long hold, else a randomly chosen stall pattern
    always @(posedge clk)
    begin
        if (cycles % 64 == 0)
            stall_mode = $urandom_range(0, 3);
        if (hold_cycles > 0)
        begin
            out_stall <= 1'b1;
            hold_cycles--;
        end
        else
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                2: out_stall <= ($urandom_range(0, 3) != 0);
                default: out_stall <= cycles[2];
            endcase
    end

    function automatic kcdt_pkg::in_item_t noise_item(kcdt_pkg::func_t f);
        kcdt_pkg::in_item_t it;
        it.func           = f;
        it.task_id        = 22'($urandom);
        it.name_low       = {$urandom, $urandom};
        it.name_high      = {$urandom, $urandom};
        it.read_total     = {$urandom, $urandom};
        it.write_total    = {$urandom, $urandom};
        it.detail_request = 1'($urandom);
        return it;
    endfunction

    // Name of random length with nonzero bytes, zero padded, or in one case of eight fully random
    function automatic bit [127:0] make_name();
        bit [127:0] n;
        int         len;
        n   = '0;
        len = $urandom_range(0, 16);
        if ($urandom_range(0, 7) == 0)
            return {$urandom, $urandom, $urandom, $urandom};
        for (int i = 0; i < len; i++)
            n[i*8 +: 8] = 8'($urandom_range(1, 255));
        return n;
    endfunction

    // Fresh bytes after the terminator: same key once cleaned
    function automatic bit [127:0] add_garbage(bit [127:0] n);
        bit ended;
        ended = 0;
        for (int i = 0; i < 16; i++)
        begin
            if (ended)
                n[i*8 +: 8] = 8'($urandom);
            if (n[i*8 +: 8] == 8'd0)
                ended = 1;
        end
        return n;
    endfunction

    function automatic bit [63:0] next_total(bit [63:0] t);
        case ($urandom_range(0, 9))
            0: return t;
            1, 2, 3, 4: return t + 64'($urandom_range(0, 12 * 1024 * 1024));
            5: return {$urandom, $urandom};
            default: return t + 64'($urandom_range(0, 65536));
        endcase
    endfunction

    function automatic kcdt_pkg::in_item_t pool_sample(int k);
        kcdt_pkg::in_item_t it;
        it            = noise_item(kcdt_pkg::FUNC_SAMPLE);
        pool_rd[k]    = next_total(pool_rd[k]);
        pool_wr[k]    = next_total(pool_wr[k]);
        it.task_id    = pool_id[k];
        {it.name_high, it.name_low} = ($urandom_range(0, 3) == 0) ?
                                      add_garbage(pool_name[k]) : pool_name[k];
        it.read_total  = pool_rd[k];
        it.write_total = pool_wr[k];
        return it;
    endfunction

    function automatic kcdt_pkg::in_item_t key_item(bit [21:0] id, bit [127:0] nm,
                                                    bit [63:0] rd, bit [63:0] wr);
        kcdt_pkg::in_item_t it;
        it             = noise_item(kcdt_pkg::FUNC_SAMPLE);
        it.task_id     = id;
        {it.name_high, it.name_low} = nm;
        it.read_total  = rd;
        it.write_total = wr;
        return it;
    endfunction

    function automatic kcdt_pkg::in_item_t scan_item(kcdt_pkg::func_t f, bit detail);
        kcdt_pkg::in_item_t it;
        it                = noise_item(f);
        it.detail_request = detail;
        return it;
    endfunction

    // Offer one item in bursts; valid is lowered only when a gap follows
    task send_item(kcdt_pkg::in_item_t it);
        int gap;
        in_item  <= it;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_input(it);
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Stop offering and wait until every expected item has come back
    task drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task write_reg(logic [kcdt_pkg::CFG_IDX_W-1:0] idx,
                   logic [kcdt_pkg::CFG_DAT_W-1:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.set_reg(idx, data);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task set_regs(logic [15:0] thresh, logic [6:0] lim);
        drain();
        repeat (SWEEP_WAIT) @(posedge clk);
        write_reg(kcdt_pkg::REG_THRESHOLD, thresh);
        write_reg(kcdt_pkg::REG_LIMIT, {9'd0, lim});
    endtask

    // One scan: begin, samples picked at random from the pool with occasional noise and no-op items, end
    task run_scan();
        int n;
        send_item(scan_item(kcdt_pkg::FUNC_BEGIN, 1'($urandom)));
        n = $urandom_range(5, 40);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 19) == 0)
                send_item(noise_item(kcdt_pkg::FUNC_NONE));
            else if ($urandom_range(0, 19) == 0)
                send_item(noise_item(kcdt_pkg::FUNC_SAMPLE));
            else
                send_item(pool_sample($urandom_range(0, POOL_SIZE - 1)));
        end
        send_item(scan_item(kcdt_pkg::FUNC_END, 1'($urandom)));
    endtask

    task run_phase(int items);
        int start;
        start = sb.noted;
        while (sb.noted - start < items)
            run_scan();
    endtask

    initial
    begin
        bit [127:0] ones;
        bit [127:0] short_name;
        sb = new();
        sb.reset_state();
        hold_cycles = 0;
        stall_mode  = 0;
        burst_left  = 1;
        ones        = '1;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_item   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= kcdt_pkg::REG_THRESHOLD;
        cfg_data  <= '0;
        for (int k = 0; k < POOL_SIZE; k++)
        begin
            pool_id[k]   = (k < 40) ? (22'(k % 8) + 22'(N_BUCKETS * $urandom_range(0, 16383)))
                                    : 22'($urandom);
            pool_name[k] = make_name();
            pool_rd[k]   = ($urandom_range(0, 1) == 0) ? {$urandom, $urandom} : 64'd0;
            pool_wr[k]   = ($urandom_range(0, 1) == 0) ? {$urandom, $urandom} : 64'd0;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: field extremes, zero and wrapping deltas, name tail, full bucket
        set_regs(16'd2, 7'd100);
        short_name = 128'h0000_0000_0000_0000_0000_0000_0063_6261;
        send_item(scan_item(kcdt_pkg::FUNC_BEGIN, 1'b1));
        send_item(key_item(22'd0, '0, 64'd0, 64'd0));
        send_item(key_item(22'h3FFFFF, ones, '1, '1));
        send_item(key_item(22'h3FFFFF, ones, '1, '1));
        send_item(key_item(22'h3FFFFF, ones, 64'd0, 64'd5 << 20));
        send_item(key_item(22'd7, short_name, 64'd3 << 20, 64'd0));
        send_item(key_item(22'd7, add_garbage(short_name), 64'd9 << 20, 64'd1));
        for (int j = 0; j < 6; j++)
            send_item(key_item(22'(9 + N_BUCKETS * j), short_name, 64'(j) << 21, '1));
        send_item(noise_item(kcdt_pkg::FUNC_NONE));
        send_item(scan_item(kcdt_pkg::FUNC_END, 1'b0));
        send_item(scan_item(kcdt_pkg::FUNC_BEGIN, 1'b0));
        send_item(key_item(22'd7, short_name, 64'd0, 64'd0));
        send_item(scan_item(kcdt_pkg::FUNC_END, 1'b1));
        send_item(scan_item(kcdt_pkg::FUNC_END, 1'b0));

        // Random scans across register settings
        set_regs(16'd0, 7'd3);
        run_phase(210);
        set_regs(16'hFFFF, 7'd127);
        hold_cycles = 400;
        run_phase(210);
        set_regs(16'($urandom_range(0, 8)), 7'd0);
        run_phase(210);
        drain();
        set_regs(16'd1, 7'($urandom_range(1, 127)));
        hold_cycles = 300;
        run_phase(210);
        set_regs(16'($urandom), 7'($urandom));
        run_phase(200);

        drain();
        repeat (SWEEP_WAIT) @(posedge clk);
        if (sb.pending() != 0)
            sb.report("expected items left over");
        if (sb.errors == 0)
            $display("keyed_counter_delta_table_unit_tb: done, clean");
        else
            $display("keyed_counter_delta_table_unit_tb: done, errors");
        $finish;
    end

endmodule
`default_nettype wire
